[rtl/core/sorted_write_overlay_map_defines.svh]
// Assertion macros shared by the overlay map RTL.
// Include with the bare file name; no other dependencies.
`ifndef SORTED_WRITE_OVERLAY_MAP_DEFINES_SVH
`define SORTED_WRITE_OVERLAY_MAP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SWOM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SWOM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/core/swom_pkg.sv]
// Types and codes for the sorted write overlay map.
// No dependencies.
`timescale 1ns / 1ps
package swom_pkg;
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_MAXEND = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_FULL     = 3'd2,
    ST_SEGMENT  = 3'd3,
    ST_NO_OVL   = 3'd4,
    ST_MAX_END  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_SCAN  = 2'd1,
    FSM_EMIT  = 2'd2
  } fsm_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [47:0] offset;
    logic [31:0] length;
    logic [15:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] result_handle;
    logic [31:0] source_offset;
    logic [31:0] dest_offset;
    logic [31:0] byte_count;
    logic [48:0] max_end;
    logic        last;
  } out_item_t;

  // Stored write record handed between cells.
  typedef struct packed {
    logic [47:0] offset;
    logic [31:0] length;
    logic [15:0] handle;
  } entry_t;

  // Broadcast command from the controller to every cell.
  typedef struct packed {
    logic   ins;      // shift-insert the key at its sorted place
    logic   repl;     // overwrite the matching entry
    logic   rotate;   // rotate the chain one step toward cell 0
    entry_t key;
  } cell_cmd_t;
endpackage

[rtl/core/sorted_write_overlay_map.sv]
// Sorted write overlay map: top level, controller and cell chain; needs swom_pkg,
// swom_cell and sorted_write_overlay_map_defines.svh.
// Insert: the key is compared in SCAN and the result is registered into the output buffer;
// a new transfer is taken only once the controller is back in IDLE. Query: DEPTH rotation steps
// past cell 0, at most one segment per step, each step waiting while the output is stalled.
// Reset (rst_n, synchronous) clears the fill count and controller only.
`timescale 1ns / 1ps
`include "sorted_write_overlay_map_defines.svh"
module sorted_write_overlay_map #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  swom_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output swom_pkg::out_item_t  out_data
);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  swom_pkg::fsm_t      state_r, state_nxt;
  swom_pkg::in_item_t  req_r, req_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                found_r, found_nxt;
  logic [48:0]         mend_r, mend_nxt;
  swom_pkg::out_item_t pend_r, pend_nxt;   // held segment awaiting successor
  logic                pend_v_r, pend_v_nxt;
  swom_pkg::out_item_t obuf_r, obuf_nxt;
  logic                ov_r, ov_nxt;

  swom_pkg::cell_cmd_t cmd;
  swom_pkg::entry_t    ents [DEPTH];
  logic [DEPTH-1:0]    less_v, match_v, occ_v;

  // Cells below the count are live; during a rotate, cell 0 holds the entry at index idx_r.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ_v[i] = (CW'(i) < count_r);
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      swom_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .occ_in   (occ_v[g]),
        .prev_less((g == 0) ? 1'b1 : less_v[(g == 0) ? 0 : g-1]),
        .prev_ent ((g == 0) ? cmd.key : ents[(g == 0) ? 0 : g-1]),
        .next_ent (ents[(g + 1) % DEPTH]),
        .ent      (ents[g]),
        .less     (less_v[g]),
        .match    (match_v[g])
      );
    end
  endgenerate

  // Segment math on the entry sitting at cell 0 this cycle.
  logic [48:0] woff, wend, roff, rend, lo, hi;
  logic        ovl, past;
  always_comb begin
    woff = {1'b0, ents[0].offset};
    wend = woff + {17'd0, ents[0].length};
    roff = {1'b0, req_r.offset};
    rend = roff + {17'd0, req_r.length};
    past = (woff >= rend);
    ovl  = !past && (wend > roff);
    lo   = (woff > roff) ? woff : roff;
    hi   = (wend < rend) ? wend : rend;
  end

  logic out_free;
  assign out_free = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_data  = obuf_r;
  assign in_ready  = (state_r == swom_pkg::FSM_IDLE) && out_free;

  always_comb begin
    swom_pkg::out_item_t o;
    state_nxt  = state_r;
    req_nxt    = req_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    mend_nxt   = mend_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    obuf_nxt   = obuf_r;
    ov_nxt     = ov_r && !out_ready;
    cmd        = '0;
    cmd.key    = '{offset: req_r.offset, length: req_r.length, handle: req_r.handle};
    o          = '0;
    o.last     = 1'b1;
    unique case (state_r)
      swom_pkg::FSM_IDLE: begin
        if (in_valid && in_ready && in_data.action != swom_pkg::ACT_NONE) begin
          req_nxt    = in_data;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          mend_nxt   = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = swom_pkg::FSM_SCAN;
        end
      end
      swom_pkg::FSM_SCAN: begin
        if (req_r.action == swom_pkg::ACT_INSERT) begin
          if (out_free) begin
            // Compare the key against every cell in parallel, then act.
            if (|match_v) begin
              cmd.repl = 1'b1;
              o.status = swom_pkg::ST_REPLACED;
              for (int i = 0; i < DEPTH; i++) begin
                if (match_v[i]) o.result_handle = ents[i].handle;
              end
            end else if (count_r == CW'(DEPTH)) begin
              o.status = swom_pkg::ST_FULL;
            end else begin
              cmd.ins   = 1'b1;
              count_nxt = count_r + 1'b1;
              o.status  = swom_pkg::ST_INSERTED;
            end
            obuf_nxt  = o;
            ov_nxt    = 1'b1;
            state_nxt = swom_pkg::FSM_IDLE;
          end
        end else begin
          state_nxt = swom_pkg::FSM_EMIT;
        end
      end
      swom_pkg::FSM_EMIT: begin
        // Each cycle the output is free: look at cell 0, then rotate the chain one step.
        if (out_free) begin
          logic live;
          live = (CW'(idx_r) < count_r);
          cmd.rotate = 1'b1;
          idx_nxt    = idx_r + 1'b1;
          if (req_r.action == swom_pkg::ACT_MAXEND) begin
            if (live && wend > mend_r) mend_nxt = wend;
          end else if (live && !found_r && ovl) begin
            if (pend_v_r) begin
              obuf_nxt = pend_r;
              ov_nxt   = 1'b1;
            end
            pend_nxt.status        = swom_pkg::ST_SEGMENT;
            pend_nxt.result_handle = ents[0].handle;
            pend_nxt.source_offset = 32'(lo - woff);
            pend_nxt.dest_offset   = 32'(lo - roff);
            pend_nxt.byte_count    = 32'(hi - lo);
            pend_nxt.max_end       = '0;
            pend_nxt.last          = 1'b0;
            pend_v_nxt             = 1'b1;
          end else if (live && past) begin
            found_nxt = 1'b1;   // stop emitting, keep rotating home
          end
          if (idx_r == IW'(DEPTH - 1)) begin
            if (req_r.action == swom_pkg::ACT_MAXEND) begin
              o.status  = swom_pkg::ST_MAX_END;
              o.max_end = (live && wend > mend_r) ? wend : mend_r;
              obuf_nxt  = o;
              ov_nxt    = 1'b1;
              state_nxt = swom_pkg::FSM_IDLE;
            end else begin
              state_nxt = swom_pkg::FSM_SCAN;
              req_nxt.action = swom_pkg::ACT_NONE;
            end
          end
        end
      end
      default: begin
        state_nxt = swom_pkg::FSM_IDLE;
      end
    endcase
    // Flush the held segment (or no-overlap) once the rotation is done.
    if (state_r == swom_pkg::FSM_SCAN && req_r.action == swom_pkg::ACT_NONE) begin
      cmd = '0;
      state_nxt = swom_pkg::FSM_SCAN;
      if (out_free) begin
        if (pend_v_r) begin
          obuf_nxt      = pend_r;
          obuf_nxt.last = 1'b1;
        end else begin
          obuf_nxt        = '0;
          obuf_nxt.status = swom_pkg::ST_NO_OVL;
          obuf_nxt.last   = 1'b1;
        end
        ov_nxt     = 1'b1;
        pend_v_nxt = 1'b0;
        state_nxt  = swom_pkg::FSM_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= swom_pkg::FSM_IDLE;
      count_r  <= '0;
      ov_r     <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ov_r     <= ov_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    mend_r  <= mend_nxt;
    pend_r  <= pend_nxt;
    obuf_r  <= obuf_nxt;
  end

  `SWOM_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_r <= CW'(DEPTH), "fill count above depth")
  `SWOM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `SWOM_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != swom_pkg::FSM_IDLE, !in_ready, "transfer taken while busy")
endmodule

[rtl/core/swom_cell.sv]
// One storage cell of the overlay map chain.
// Depends on swom_pkg.
`timescale 1ns / 1ps
module swom_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  swom_pkg::cell_cmd_t cmd,
  input  logic                occ_in,     // this cell holds a live entry
  input  logic                prev_less,  // left neighbor is live and below key
  input  swom_pkg::entry_t    prev_ent,   // left neighbor's entry
  input  swom_pkg::entry_t    next_ent,   // right neighbor's entry (rotate)
  output swom_pkg::entry_t    ent,
  output logic                less,       // live and offset below key
  output logic                match       // live and offset equal to key
);
  swom_pkg::entry_t ent_r;
  swom_pkg::entry_t ent_nxt;

  assign ent   = ent_r;
  assign less  = occ_in && (ent_r.offset < cmd.key.offset);
  assign match = occ_in && (ent_r.offset == cmd.key.offset);

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.rotate) begin
      ent_nxt = next_ent;
    end else if (cmd.repl && match) begin
      ent_nxt.length = cmd.key.length;
      ent_nxt.handle = cmd.key.handle;
    end else if (cmd.ins && !less) begin
      // Take the key where the boundary falls, else shift right.
      ent_nxt = prev_less ? cmd.key : prev_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  logic unused_rst;
  assign unused_rst = rst_n;
endmodule

[tb/sv/tb.sv]
// Testbench for sorted_write_overlay_map: random and directed transfers checked
// against a behavioral table model. Depends on swom_pkg and the RTL top level.
`timescale 1ns / 1ps
module tb;
  localparam int DEPTH = 16;
  localparam int LIMIT = 2000000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  swom_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  swom_pkg::out_item_t out_data;

  sorted_write_overlay_map #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Shadow copy of the write table, kept sorted by offset.
  logic [47:0] tbl_off [DEPTH];
  logic [31:0] tbl_len [DEPTH];
  logic [15:0] tbl_hnd [DEPTH];
  int          tbl_cnt;

  swom_pkg::in_item_t  pending_writes[$];
  swom_pkg::out_item_t expected_results[$];
  int        fail_count;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_idle_pct;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic swom_pkg::out_item_t blank_result(swom_pkg::status_t st);
    swom_pkg::out_item_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Compute the results of one accepted transfer and update the shadow table.
  function automatic void predict_results(swom_pkg::in_item_t it);
    int pos;
    int k;
    logic [48:0] rend, wend, lo, hi, mend;
    swom_pkg::out_item_t r;
    unique case (swom_pkg::action_t'(it.action))
      swom_pkg::ACT_INSERT: begin
        pos = 0;
        while (pos < tbl_cnt && tbl_off[pos] < it.offset) pos++;
        if (pos < tbl_cnt && tbl_off[pos] == it.offset) begin
          r = blank_result(swom_pkg::ST_REPLACED);
          r.result_handle = tbl_hnd[pos];
          tbl_len[pos] = it.length;
          tbl_hnd[pos] = it.handle;
          expected_results.push_back(r);
        end else if (tbl_cnt >= DEPTH) begin
          expected_results.push_back(blank_result(swom_pkg::ST_FULL));
        end else begin
          for (int i = tbl_cnt; i > pos; i--) begin
            tbl_off[i] = tbl_off[i-1];
            tbl_len[i] = tbl_len[i-1];
            tbl_hnd[i] = tbl_hnd[i-1];
          end
          tbl_off[pos] = it.offset;
          tbl_len[pos] = it.length;
          tbl_hnd[pos] = it.handle;
          tbl_cnt++;
          expected_results.push_back(blank_result(swom_pkg::ST_INSERTED));
        end
      end
      swom_pkg::ACT_QUERY: begin
        k = 0;
        rend = {1'b0, it.offset} + it.length;
        for (int i = 0; i < tbl_cnt; i++) begin
          wend = {1'b0, tbl_off[i]} + tbl_len[i];
          if ({1'b0, tbl_off[i]} >= rend) break;
          if (wend <= {1'b0, it.offset}) continue;
          lo = (tbl_off[i] > it.offset) ? {1'b0, tbl_off[i]} : {1'b0, it.offset};
          hi = (wend < rend) ? wend : rend;
          r = '0;
          r.status = swom_pkg::ST_SEGMENT;
          r.result_handle = tbl_hnd[i];
          r.source_offset = 32'(lo - tbl_off[i]);
          r.dest_offset = 32'(lo - it.offset);
          r.byte_count = 32'(hi - lo);
          expected_results.push_back(r);
          k++;
        end
        if (k == 0) expected_results.push_back(blank_result(swom_pkg::ST_NO_OVL));
        else expected_results[$].last = 1'b1;
      end
      swom_pkg::ACT_MAXEND: begin
        mend = '0;
        for (int i = 0; i < tbl_cnt; i++)
          if ({1'b0, tbl_off[i]} + tbl_len[i] > mend) mend = {1'b0, tbl_off[i]} + tbl_len[i];
        r = blank_result(swom_pkg::ST_MAX_END);
        r.max_end = mend;
        expected_results.push_back(r);
      end
      default: ;  // unused action: no result, state unchanged
    endcase
  endfunction

  // Driver: hold valid and payload until the transfer, then advance the queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_results(in_data);
      if (pending_writes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_writes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count++;
        end else if (out_data !== expected_results[0]) begin
          $display("%0t: mismatch expected %h actual %h", $time,
                   expected_results[0], out_data);
          fail_count++;
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: drop the run if it takes far longer than the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("sorted_write_overlay_map test failed");
      $finish;
    end
  end

  function automatic swom_pkg::in_item_t make_item(swom_pkg::action_t a, logic [47:0] o,
                                                   logic [31:0] l, logic [15:0] h);
    swom_pkg::in_item_t it;
    it.action = a;
    it.offset = o;
    it.length = l;
    it.handle = h;
    return it;
  endfunction

  // Random item: offsets mostly in a narrow region so writes and windows overlap.
  function automatic swom_pkg::in_item_t rand_item();
    swom_pkg::in_item_t it;
    int sel;
    sel = $urandom_range(99);
    it.handle = 16'($urandom);
    if (sel < 45) it.action = swom_pkg::ACT_INSERT;
    else if (sel < 85) it.action = swom_pkg::ACT_QUERY;
    else if (sel < 95) it.action = swom_pkg::ACT_MAXEND;
    else it.action = swom_pkg::ACT_NONE;
    if ($urandom_range(9) == 0) begin
      it.offset = {16'($urandom), 32'($urandom)};
      it.length = 32'($urandom);
    end else begin
      it.offset = 48'($urandom_range(4095));
      if ($urandom_range(7) == 0) it.offset = 48'hFFFF_FFFF_F000 + it.offset;
      it.length = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(600));
    end
    return it;
  endfunction

  task automatic drain();
    while (pending_writes.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (2 * DEPTH + 4) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    tbl_cnt = 0;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 8;
    recv_idle_pct = 73;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table cases, extremes, fill past full, replace when full.
    pending_writes.push_back(make_item(swom_pkg::ACT_MAXEND, '0, '0, '0));
    pending_writes.push_back(make_item(swom_pkg::ACT_QUERY, '0, '1, '0));
    pending_writes.push_back(make_item(swom_pkg::ACT_NONE, '1, '1, '1));
    pending_writes.push_back(make_item(swom_pkg::ACT_INSERT, '1, '1, '1));
    pending_writes.push_back(make_item(swom_pkg::ACT_MAXEND, '0, '0, '0));
    pending_writes.push_back(make_item(swom_pkg::ACT_INSERT, 48'd100, 32'd0, 16'h00AA));
    pending_writes.push_back(make_item(swom_pkg::ACT_QUERY, 48'd50, 32'd100, '0));
    pending_writes.push_back(make_item(swom_pkg::ACT_QUERY, 48'd100, 32'd0, '0));
    for (int i = 0; i < 15; i++)
      pending_writes.push_back(make_item(swom_pkg::ACT_INSERT, 48'(i * 40), 32'd60, 16'(i)));
    pending_writes.push_back(make_item(swom_pkg::ACT_INSERT, 48'd7, 32'd5, 16'h5555));
    pending_writes.push_back(make_item(swom_pkg::ACT_INSERT, 48'd80, 32'd10, 16'hBEEF));
    pending_writes.push_back(make_item(swom_pkg::ACT_QUERY, '0, '1, '0));
    pending_writes.push_back(make_item(swom_pkg::ACT_MAXEND, '0, '0, '0));
    drain();

    // Random phases with the three idling profiles; the table carries over between phases.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 73; recv_idle_pct = 8; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int n = 0; n < 170; n++) pending_writes.push_back(rand_item());
      drain();
    end

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("sorted_write_overlay_map test passed");
    end else begin
      $display("sorted_write_overlay_map test failed");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/swom_pkg.sv
rtl/core/swom_cell.sv
rtl/core/sorted_write_overlay_map.sv
tb/sv/tb.sv
